// File: design/tpspd_pkg.sv
package tpspd_pkg;

  localparam int ANGLE_BITS_DEF      = 16;
  localparam int SINE_TABLE_BITS_DEF = 10;

  localparam logic [15:0] PWM_PERIOD_RESET = 16'd1000;

  // result queue behind the datapath; also bounds items in flight
  localparam int OUT_DEPTH = 4;
  localparam int PTR_W     = $clog2(OUT_DEPTH);
  localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

  // duty = floor(u * strength * period / (2^16 * 25600)), 25600 = 25 * 2^10
  // -> floor((P >> 26) / 25), the /25 done as *ceil(2^27/25) >> 27 (exact below 2^22)
  localparam int PROD1_W     = 32;
  localparam int PROD2_W     = 48;
  localparam int DIV_SHIFT   = 26;
  localparam int V_W         = PROD2_W - DIV_SHIFT;
  localparam int RECIP_SHIFT = 27;
  localparam int RECIP_W     = 23;
  localparam logic [RECIP_W-1:0] RECIP_MUL =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd24) / 64'd25);
  localparam int MULR_W      = V_W + RECIP_W;
  localparam int QUO_W       = MULR_W - RECIP_SHIFT;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [2:0] {
    PH_A = 3'b001,
    PH_B = 3'b010,
    PH_C = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0]  axis;
    logic [15:0] angle;
    logic [15:0] strength;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  axis_out;
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
  } res_t;

  // sin((pi/2) * k / 2^(tb-2)) in Q1.15, Taylor series in Q30 through x^17
  function automatic logic signed [15:0] quarter_sine(input longint unsigned k,
                                                      input int unsigned tb);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned q;
    longint          sum;
    x    = (HALF_PI_Q30 * k) >> (tb - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    q = (($unsigned(sum) << 15) + (64'd1 << 29)) >> 30;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return 16'(q);
  endfunction

  // full-wave table entry i of 2^tb, mirrored from the quarter wave
  function automatic logic signed [15:0] sine_entry(input int unsigned i,
                                                    input int unsigned tb);
    int unsigned qs;
    int unsigned quarter;
    int unsigned quad;
    int unsigned r;
    logic signed [15:0] v;
    qs      = tb - 2;
    quarter = 1 << qs;
    quad    = (i >> qs) & 3;
    r       = i & (quarter - 1);
    case (quad)
      0:       v = quarter_sine(r, tb);
      1:       v = quarter_sine(quarter - r, tb);
      2:       v = -quarter_sine(r, tb);
      default: v = -quarter_sine(quarter - r, tb);
    endcase
    if (quad == 3 && r == 0) begin
      v = 16'sh8000;
    end
    return v;
  endfunction

endpackage

// File: design/three_phase_sine_pwm_duty_top.sv
// Three-phase sinusoidal PWM compare generator.
// cmd channel (cmd_valid / cmd_stall / cmd): one transfer carries axis, electrical
//   angle (fraction of a turn, wraps) and strength (Q8.8 percent, 25600 = 100%).
// res channel (res_valid / res_stall / res): one transfer per cmd, in order, with
//   the axis and compare values for phases at angle, +120 and +240 degrees.
// cfg_wr_en / cfg_wr_data write pwm_period (full scale and clamp); write it only
//   while no command is in flight.
// The three phases share one sine ROM port, one lookup per cycle, so the ROM port
//   sets the command rate; a new command can load while phase C is looked up.
// Path: from cmd transfer to res_valid, three lookups (the last one into the ROM
//   register), two multiplies, reciprocal divide by 25, clamp/collect into the
//   queue.
// Stall: cmd_stall is high during the phase A and B lookups after each transfer, and
//   also once 4 commands are unfinished; results wait in a 4-entry queue, so
//   commands keep flowing for a while when the receiver stalls.
// Reset: synchronous; clears the pipeline and queue and sets pwm_period to 1000.
//   The sine ROM is constant, so no clearing pass is needed.
module three_phase_sine_pwm_duty_top #(
  parameter int ANGLE_BITS      = tpspd_pkg::ANGLE_BITS_DEF,
  parameter int SINE_TABLE_BITS = tpspd_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  tpspd_pkg::cmd_t  cmd,
  output logic             res_valid,
  input  logic             res_stall,
  output tpspd_pkg::res_t  res,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data
);

  localparam int SineN = 1 << SINE_TABLE_BITS;
  // phase offsets: round(2^AB / 3) and round(2^(AB+1) / 3)
  localparam logic [ANGLE_BITS-1:0] OffB =
    ANGLE_BITS'(((64'd1 << ANGLE_BITS) + 64'd1) / 64'd3);
  localparam logic [ANGLE_BITS-1:0] OffC =
    ANGLE_BITS'(((64'd1 << (ANGLE_BITS + 1)) + 64'd1) / 64'd3);

  // ---------------- configuration ----------------
  logic [15:0] pwm_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period <= tpspd_pkg::PWM_PERIOD_RESET;
    end else if (cfg_wr_en) begin
      pwm_period <= cfg_wr_data;
    end
  end

  // ---------------- sine ROM ----------------
  logic signed [15:0] sine_rom [SineN];

  for (genvar gi = 0; gi < SineN; gi++) begin : g_rom
    assign sine_rom[gi] = tpspd_pkg::sine_entry(gi, SINE_TABLE_BITS);
  end

  // ---------------- issue stage ----------------
  // Holds one command and walks phases A, B, C, one ROM lookup each.
  logic                       cmd_xfer;
  logic                       res_xfer;
  logic [tpspd_pkg::OCNT_W-1:0] outstanding;
  logic                       iss_busy;
  tpspd_pkg::phase_t          iss_ph;
  logic [1:0]                 iss_axis;
  logic [ANGLE_BITS-1:0]      iss_ang;
  logic [15:0]                iss_str;
  logic [ANGLE_BITS-1:0]      cmd_ang;
  logic [ANGLE_BITS-1:0]      ph_off;
  logic [ANGLE_BITS-1:0]      ph_ang;
  logic [SINE_TABLE_BITS-1:0] rom_idx;

  if (ANGLE_BITS <= 16) begin : g_ang_narrow
    assign cmd_ang = cmd.angle[ANGLE_BITS-1:0];
  end else begin : g_ang_wide
    assign cmd_ang = {{(ANGLE_BITS - 16){1'b0}}, cmd.angle};
  end

  // a new command may load in the cycle phase C is looked up
  assign cmd_stall = (iss_busy && iss_ph != tpspd_pkg::PH_C) ||
                     (outstanding == tpspd_pkg::OCNT_W'(tpspd_pkg::OUT_DEPTH));
  assign cmd_xfer  = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_busy <= 1'b0;
      iss_ph   <= tpspd_pkg::PH_A;
    end else if (cmd_xfer) begin
      iss_busy <= 1'b1;
      iss_ph   <= tpspd_pkg::PH_A;
    end else if (iss_busy) begin
      unique case (iss_ph)
        tpspd_pkg::PH_A: iss_ph <= tpspd_pkg::PH_B;
        tpspd_pkg::PH_B: iss_ph <= tpspd_pkg::PH_C;
        default: begin
          iss_ph   <= tpspd_pkg::PH_A;
          iss_busy <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      iss_axis <= cmd.axis;
      iss_ang  <= cmd_ang;
      iss_str  <= cmd.strength;
    end
  end

  always_comb begin
    unique case (iss_ph)
      tpspd_pkg::PH_A: ph_off = '0;
      tpspd_pkg::PH_B: ph_off = OffB;
      default:         ph_off = OffC;
    endcase
  end

  assign ph_ang = iss_ang + ph_off;   // wraps mod 2^ANGLE_BITS

  // table index: top SINE_TABLE_BITS of the phase, or the phase shifted up
  if (ANGLE_BITS >= SINE_TABLE_BITS) begin : g_idx_trunc
    assign rom_idx = ph_ang[ANGLE_BITS-1 -: SINE_TABLE_BITS];
  end else begin : g_idx_shift
    assign rom_idx = {ph_ang, {(SINE_TABLE_BITS - ANGLE_BITS){1'b0}}};
  end

  // ---------------- S1: ROM read ----------------
  logic               s1_vld;
  tpspd_pkg::phase_t  s1_ph;
  logic [1:0]         s1_axis;
  logic [15:0]        s1_str;
  logic signed [15:0] rom_q;
  logic [15:0]        s1_u;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= iss_busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_ph   <= iss_ph;
    s1_axis <= iss_axis;
    s1_str  <= iss_str;
    rom_q   <= sine_rom[rom_idx];
  end

  // (sin + 1) / 2 in Q0.16: entry + 32768 is a flip of the sign bit
  assign s1_u = {~rom_q[15], rom_q[14:0]};

  // ---------------- S2: u * strength ----------------
  logic                            s2_vld;
  tpspd_pkg::phase_t               s2_ph;
  logic [1:0]                      s2_axis;
  logic [tpspd_pkg::PROD1_W-1:0]   s2_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_ph   <= s1_ph;
    s2_axis <= s1_axis;
    s2_prod <= tpspd_pkg::PROD1_W'(s1_u) * tpspd_pkg::PROD1_W'(s1_str);
  end

  // ---------------- S3: * period ----------------
  logic                            s3_vld;
  tpspd_pkg::phase_t               s3_ph;
  logic [1:0]                      s3_axis;
  logic [tpspd_pkg::PROD2_W-1:0]   s3_prod;
  logic [tpspd_pkg::MULR_W-1:0]    s3_recip;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    s3_ph   <= s2_ph;
    s3_axis <= s2_axis;
    s3_prod <= tpspd_pkg::PROD2_W'(s2_prod) * tpspd_pkg::PROD2_W'(pwm_period);
  end

  // divide by 2^26 * 25: shift, then reciprocal multiply
  assign s3_recip = tpspd_pkg::MULR_W'(s3_prod[tpspd_pkg::PROD2_W-1:tpspd_pkg::DIV_SHIFT]) *
                    tpspd_pkg::MULR_W'(tpspd_pkg::RECIP_MUL);

  // ---------------- S4: quotient ----------------
  logic                          s4_vld;
  tpspd_pkg::phase_t             s4_ph;
  logic [1:0]                    s4_axis;
  logic [tpspd_pkg::QUO_W-1:0]   s4_quo;
  logic [15:0]                   s4_duty;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    s4_ph   <= s3_ph;
    s4_axis <= s3_axis;
    s4_quo  <= s3_recip[tpspd_pkg::MULR_W-1:tpspd_pkg::RECIP_SHIFT];
  end

  // clamp at the period (strength above 100%)
  assign s4_duty = (s4_quo > tpspd_pkg::QUO_W'(pwm_period)) ? pwm_period : s4_quo[15:0];

  // ---------------- collect and result queue ----------------
  logic [15:0]                  col_a;
  logic [15:0]                  col_b;
  logic                         push;
  tpspd_pkg::res_t              res_q [tpspd_pkg::OUT_DEPTH];
  logic [tpspd_pkg::PTR_W-1:0]  wr_ptr;
  logic [tpspd_pkg::PTR_W-1:0]  rd_ptr;
  logic [tpspd_pkg::OCNT_W-1:0] q_cnt;

  assign push = s4_vld && s4_ph == tpspd_pkg::PH_C;

  always_ff @(posedge clk) begin
    if (s4_vld && s4_ph == tpspd_pkg::PH_A) begin
      col_a <= s4_duty;
    end
    if (s4_vld && s4_ph == tpspd_pkg::PH_B) begin
      col_b <= s4_duty;
    end
    if (push) begin
      res_q[wr_ptr] <= '{axis_out: s4_axis, duty_a: col_a, duty_b: col_b, duty_c: s4_duty};
    end
  end

  assign res_valid = (q_cnt != '0);
  assign res       = res_q[rd_ptr];
  assign res_xfer  = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      q_cnt       <= '0;
      outstanding <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + tpspd_pkg::PTR_W'(1);
      end
      if (res_xfer) begin
        rd_ptr <= rd_ptr + tpspd_pkg::PTR_W'(1);
      end
      q_cnt       <= q_cnt + tpspd_pkg::OCNT_W'(push) - tpspd_pkg::OCNT_W'(res_xfer);
      outstanding <= outstanding + tpspd_pkg::OCNT_W'(cmd_xfer) -
                     tpspd_pkg::OCNT_W'(res_xfer);
    end
  end

`ifndef SYNTHESIS
  a_outstanding_cap: assert property (@(posedge clk) disable iff (rst)
    outstanding <= tpspd_pkg::OCNT_W'(tpspd_pkg::OUT_DEPTH))
    else $error("more commands in flight than queue entries");

  a_queue_within_outstanding: assert property (@(posedge clk) disable iff (rst)
    q_cnt <= outstanding)
    else $error("result queue holds more than commands in flight");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (q_cnt != tpspd_pkg::OCNT_W'(tpspd_pkg::OUT_DEPTH) || res_xfer))
    else $error("result queue overflow");

  a_issue_start: assert property (@(posedge clk) disable iff (rst)
    cmd_xfer |=> (iss_busy && iss_ph == tpspd_pkg::PH_A))
    else $error("accepted command did not start at phase A");

  a_push_follows_issue: assert property (@(posedge clk) disable iff (rst)
    (iss_busy && iss_ph == tpspd_pkg::PH_C) |=> ##3 push)
    else $error("phase C lookup did not reach the queue");
`endif

endmodule

// File: dv/tb_three_phase_sine_pwm_duty_top.sv
`timescale 1ns / 1ps

module tb_three_phase_sine_pwm_duty_top;

  // Cycle budget for the whole run. The slowest correct run covers about 1100 items,
  // plus receiver stalls, the long hold-off and the drains between period changes.
  localparam int unsigned RUN_LIMIT = 200000;

  // Cycles to settle after the last result.
  localparam int unsigned SETTLE_CYCLES = 12;

  localparam int unsigned RAND_PHASES    = 6;
  localparam int unsigned ITEMS_PER_PHASE = 184;
  localparam int unsigned HOLD_AFTER     = 400;  // transfers before the long hold-off
  localparam int unsigned HOLD_CYCLES    = 150;

  // The predictor uses its own copy of the fixed-point constants.
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;  // pi/2 in Q30
  localparam longint unsigned DUTY_DIVISOR     = 64'd65536 * 64'd25600;
  localparam logic [15:0]     PHASE_B_OFS      = 16'd21845;  // round(2^16 / 3)
  localparam logic [15:0]     PHASE_C_OFS      = 16'd43691;  // round(2^17 / 3)
  localparam logic [15:0]     FULL_STRENGTH    = 16'd25600;  // 100 percent, Q8.8
  localparam logic [15:0]     RESET_PERIOD     = 16'd1000;

  typedef enum int {
    RX_FLOW,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE
  } rx_mode_t;

  // One row of the directed table. The period is applied before the command
  // is sent. When fixed_res is set, want holds the result written out by hand.
  typedef struct {
    logic [15:0]     period;
    tpspd_pkg::cmd_t c;
    bit              fixed_res;
    tpspd_pkg::res_t want;
  } dir_row_t;

  localparam int unsigned N_DIR = 22;
  localparam tpspd_pkg::res_t NO_RES = '0;

  logic            clk;
  logic            rst;
  logic            cmd_valid;
  logic            cmd_stall;
  tpspd_pkg::cmd_t cmd;
  logic            res_valid;
  logic            res_stall;
  tpspd_pkg::res_t res;
  logic            cfg_wr_en;
  logic [15:0]     cfg_wr_data;

  // Predictor state. The sine table is the only constant, and the period is
  // the only register.
  int              sine_q15 [1024];
  logic [15:0]     period_model;

  tpspd_pkg::res_t pending_duties[$];
  bit              failed;
  int unsigned     cmds_sent;
  int unsigned     burst_left;
  int unsigned     cycle_count;
  dir_row_t        dir_rows [N_DIR];

  three_phase_sine_pwm_duty_top u_top (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res         (res),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // sin((pi/2) * k / 256) in Q1.15. This is a Q30 Taylor series through the
  // x^17 term, rounded half up and saturated at +32767.
  function automatic int quarter_wave(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned q;
    longint          acc;
    int unsigned     n;
    x    = (QUARTER_TURN_Q30 * k) / 64'd256;
    x2   = (x * x) >> 30;
    term = x;
    acc  = $signed(x);
    for (n = 1; n <= 8; n++) begin
      term = (term * x2) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    q = ((longint'(acc) << 15) + (64'd1 << 29)) >> 30;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return int'(q);
  endfunction

  // Build the full wave by mirroring the quarter wave. The entry at
  // three-quarter turn is pinned to -32768.
  function automatic void fill_sine_table();
    int unsigned quad;
    int unsigned r;
    for (int unsigned i = 0; i < 1024; i++) begin
      quad = i >> 8;
      r    = i & 255;
      case (quad)
        0:       sine_q15[i] = quarter_wave(r);
        1:       sine_q15[i] = quarter_wave(256 - r);
        2:       sine_q15[i] = -quarter_wave(r);
        default: sine_q15[i] = -quarter_wave(256 - r);
      endcase
      if (quad == 3 && r == 0) begin
        sine_q15[i] = -32768;
      end
    end
  endfunction

  // Compare value for one phase. It looks up the top 10 angle bits, takes
  // (sin+1)/2 in Q0.16, scales by strength and period, and clamps at the period.
  function automatic logic [15:0] compare_value(input logic [15:0] phase,
                                                input logic [15:0] strength);
    longint unsigned u;
    longint unsigned d;
    u = longint'(sine_q15[phase[15:6]] + 32768);
    d = (u * strength * period_model) / DUTY_DIVISOR;
    if (d > period_model) begin
      d = period_model;
    end
    return d[15:0];
  endfunction

  function automatic tpspd_pkg::res_t duties_for(input tpspd_pkg::cmd_t c);
    tpspd_pkg::res_t r;
    logic [15:0]     ph_b;
    logic [15:0]     ph_c;
    ph_b       = c.angle + PHASE_B_OFS;  // wraps modulo one turn
    ph_c       = c.angle + PHASE_C_OFS;
    r.axis_out = c.axis;
    r.duty_a   = compare_value(c.angle, c.strength);
    r.duty_b   = compare_value(ph_b, c.strength);
    r.duty_c   = compare_value(ph_c, c.strength);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Strength is weighted toward the interesting spots: coasting, exactly 100%,
  // overdrive that clamps, tiny values, and the full 16-bit range.
  function automatic tpspd_pkg::cmd_t random_cmd();
    tpspd_pkg::cmd_t c;
    c.axis  = 2'($urandom_range(0, 3));
    c.angle = 16'($urandom);
    case ($urandom_range(0, 9))
      0:       c.strength = 16'd0;
      1:       c.strength = FULL_STRENGTH;
      2:       c.strength = 16'($urandom_range(25601, 65535));
      3:       c.strength = 16'($urandom_range(0, 255));
      4, 5:    c.strength = 16'($urandom);
      default: c.strength = 16'($urandom_range(0, 25600));
    endcase
    return c;
  endfunction

  // Offer one command and hold it until the block takes it. The sender runs
  // in bursts. Between bursts valid drops for a random number of cycles. A
  // zero gap never lowers valid, so it is never dropped and raised in one step.
  task automatic send_cmd(input tpspd_pkg::cmd_t c, input tpspd_pkg::res_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (cmd_stall);
    pending_duties.push_back(want);
    cmds_sent++;
  endtask

  // Stop offering and let every outstanding result come out. The settle time
  // then covers the pipeline before the period changes.
  task automatic drain_block();
    cmd_valid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_duties.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [15:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    period_model = value;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall pattern. It is independent of the sender. Each span picks a
  // mode: free flowing, light stall, heavy stall, or toggling. Once, after
  // HOLD_AFTER transfers, the receiver holds off long enough for the results
  // queue to fill. The block must then stall its command input.
  // ---------------------------------------------------------------------------
  initial begin
    rx_mode_t    mode;
    int unsigned span;
    bit          held;
    res_stall = 1'b0;
    held      = 1'b0;
    forever begin
      if (!held && cmds_sent >= HOLD_AFTER) begin
        held = 1'b1;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(8, 80);
      repeat (span) begin
        case (mode)
          RX_FLOW:  res_stall <= 1'b0;
          RX_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
          default:  res_stall <= ~res_stall;
        endcase
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker. Each result transfer is compared with the oldest
  // expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tpspd_pkg::res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_duties.size() == 0) begin
        $display("%0t: result with nothing expected: axis %0d duties %0d %0d %0d",
                 $time, res.axis_out, res.duty_a, res.duty_b, res.duty_c);
        failed = 1'b1;
      end else begin
        want = pending_duties.pop_front();
        if (res.axis_out !== want.axis_out || res.duty_a !== want.duty_a ||
            res.duty_b !== want.duty_b || res.duty_c !== want.duty_c) begin
          // fields in order: axis, duty A, duty B, duty C
          $display("%0t: mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                   $time, want.axis_out, want.duty_a, want.duty_b, want.duty_c,
                   res.axis_out, res.duty_a, res.duty_b, res.duty_c);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: a hang or a lost result ends here.
  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    tpspd_pkg::cmd_t next;
    logic [15:0]     rand_periods [RAND_PHASES];

    rst          = 1'b1;
    cmd_valid    = 1'b0;
    cmd          = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    failed       = 1'b0;
    cmds_sent    = 0;
    burst_left   = 0;
    period_model = RESET_PERIOD;
    fill_sine_table();

    // Directed table. Rows with a fixed result are ones whose answer is plain:
    // coasting at zero strength, or a zero period, gives all-zero duties with
    // the axis passed through. Every other row goes through the predictor.
    dir_rows = '{
      // coast, lowest angle and axis
      '{16'd1000,  '{2'd0, 16'h0000, 16'd0},     1'b1, '{2'd0, 16'd0, 16'd0, 16'd0}},
      // coast on the undefined axis, top angle
      '{16'd1000,  '{2'd3, 16'hFFFF, 16'd0},     1'b1, '{2'd3, 16'd0, 16'd0, 16'd0}},
      // 100% at the four quadrant points of the table
      '{16'd1000,  '{2'd0, 16'h0000, 16'd25600}, 1'b0, NO_RES},
      '{16'd1000,  '{2'd1, 16'h4000, 16'd25600}, 1'b0, NO_RES},
      '{16'd1000,  '{2'd2, 16'h8000, 16'd25600}, 1'b0, NO_RES},
      '{16'd1000,  '{2'd3, 16'hC000, 16'd25600}, 1'b0, NO_RES},
      // angle wrap for the phase B and C offsets
      '{16'd1000,  '{2'd0, 16'hFFFF, 16'd25600}, 1'b0, NO_RES},
      '{16'd1000,  '{2'd1, 16'h5555, 16'd25600}, 1'b0, NO_RES},
      // overdrive, where the clamp holds at the period
      '{16'd1000,  '{2'd2, 16'hAAAB, 16'hFFFF},  1'b0, NO_RES},
      '{16'd1000,  '{2'd0, 16'h4000, 16'hFFFF},  1'b0, NO_RES},
      // smallest strength, and just over 100%
      '{16'd1000,  '{2'd1, 16'h003F, 16'd1},     1'b0, NO_RES},
      '{16'd1000,  '{2'd2, 16'h2000, 16'd25601}, 1'b0, NO_RES},
      // largest period
      '{16'hFFFF,  '{2'd0, 16'h4000, 16'hFFFF},  1'b0, NO_RES},
      '{16'hFFFF,  '{2'd3, 16'h0000, 16'd25600}, 1'b0, NO_RES},
      '{16'hFFFF,  '{2'd1, 16'h7FFF, 16'd12800}, 1'b0, NO_RES},
      // smallest nonzero period
      '{16'd1,     '{2'd0, 16'h4000, 16'hFFFF},  1'b0, NO_RES},
      '{16'd1,     '{2'd2, 16'hC000, 16'd25600}, 1'b0, NO_RES},
      // zero period clamps everything to zero
      '{16'd0,     '{2'd0, 16'h4000, 16'hFFFF},  1'b1, '{2'd0, 16'd0, 16'd0, 16'd0}},
      '{16'd0,     '{2'd3, 16'hFFFF, 16'hFFFF},  1'b1, '{2'd3, 16'd0, 16'd0, 16'd0}},
      '{16'd0,     '{2'd1, 16'h1234, 16'd25600}, 1'b1, '{2'd1, 16'd0, 16'd0, 16'd0}},
      // back at the reset period: strength MSB only, and just under 100%
      '{16'd1000,  '{2'd2, 16'h0000, 16'h8000},  1'b0, NO_RES},
      '{16'd1000,  '{2'd1, 16'h0040, 16'd25599}, 1'b0, NO_RES}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The first rows run at the reset period without a write. This checks
    // the reset value of the register.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].period != period_model) begin
        drain_block();
        write_period(dir_rows[i].period);
      end
      send_cmd(dir_rows[i].c,
               dir_rows[i].fixed_res ? dir_rows[i].want : duties_for(dir_rows[i].c));
    end

    // Random phases. The period changes between phases: both extremes, zero,
    // a small value and arbitrary values.
    rand_periods[0] = 16'hFFFF;
    rand_periods[1] = 16'd1;
    rand_periods[2] = 16'($urandom_range(2, 65534));
    rand_periods[3] = 16'd0;
    rand_periods[4] = 16'($urandom_range(2, 100));
    rand_periods[5] = 16'($urandom);

    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      drain_block();
      write_period(rand_periods[p]);
      repeat (ITEMS_PER_PHASE) begin
        next = random_cmd();
        send_cmd(next, duties_for(next));
      end
    end

    drain_block();

    if (failed) begin
      $display("simulation failed");
    end else begin
      $display("simulation ok");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/tpspd_pkg.sv
design/three_phase_sine_pwm_duty_top.sv
dv/tb_three_phase_sine_pwm_duty_top.sv
